FILE: src/lsc_pkg.sv
// ----------------------------------------------------------------------------
// lsc_pkg
// Shared field widths for the LRU slot cache core.
// ----------------------------------------------------------------------------
package lsc_pkg;

   localparam int KEY_W  = 20;  // range index key width
   localparam int SLOT_W = 4;   // width of the reported slot field

   typedef logic [KEY_W-1:0]  key_type;
   typedef logic [SLOT_W-1:0] slot_type;

endpackage

FILE: src/lru_slot_cache_core.sv
// ----------------------------------------------------------------------------
// lru_slot_cache_core
// Fully associative cache of SLOTS keys with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Path: an accepted item passes the input register, then the result register,
//   before its result is strobed.
// Throughput: one item per cycle; busy stays low, the tag compare and the
//   rank update of all slots are computed combinationally from the input register.
// Reset: synchronous, clears the fill count, sets all dirty marks and drops
//   any item in flight; keys and ranks are not cleared. No result back-pressure.
module lru_slot_cache_core #(
   parameter int SLOTS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  lsc_pkg::key_type  req_range_index,
   input  logic              req_data_available,
   output logic              rsp_valid,
   output lsc_pkg::slot_type rsp_slot,
   output logic              rsp_hit,
   output logic              rsp_evicted,
   output lsc_pkg::key_type  rsp_evicted_index,
   output logic              rsp_needs_fill
);
   import lsc_pkg::*;

   localparam int RW = $clog2(SLOTS);      // slot index and rank width
   localparam int CW = $clog2(SLOTS + 1);  // fill count width

   // input register
   logic           req_valid_ff;
   key_type        req_key_ff;
   logic           req_avail_ff;

   // slot state
   key_type        slot_key_ff  [SLOTS];
   logic [RW-1:0]  slot_rank_ff [SLOTS];
   logic [SLOTS-1:0] slot_dirty_ff;
   logic [SLOTS-1:0] slot_dirty_in;
   logic [CW-1:0]  used_ff;

   // result register
   logic           rsp_valid_ff;
   slot_type       rsp_slot_ff;
   logic           rsp_hit_ff;
   logic           rsp_evicted_ff;
   key_type        rsp_evicted_index_ff;
   logic           rsp_needs_fill_ff;

   // lookup
   logic [SLOTS-1:0] match;
   logic [SLOTS-1:0] used_vec;
   logic             hit;
   logic             full;
   logic             alloc;
   logic             evict;
   logic [RW-1:0]    hit_idx;
   logic [RW-1:0]    lru_idx;
   logic [RW-1:0]    sel_idx;
   logic             needs_fill;
   key_type          ev_key;
   logic [RW-1:0]    lim;
   logic [RW-1:0]    slot_rank_in [SLOTS];

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= start;
      end
      if (start) begin
         req_key_ff   <= req_range_index;
         req_avail_ff <= req_data_available;
      end
   end

   // parallel tag compare; keys are unique so the indexes can be or-ed
   always_comb begin
      hit_idx = '0;
      lru_idx = '0;
      for (int i = 0; i < SLOTS; i++) begin
         used_vec[i] = CW'(i) < used_ff;
         match[i]    = used_vec[i] && (slot_key_ff[i] == req_key_ff);
         if (match[i]) begin
            hit_idx = hit_idx | RW'(i);
         end
         if (slot_rank_ff[i] == RW'(SLOTS - 1)) begin
            lru_idx = lru_idx | RW'(i);
         end
      end
   end

   assign hit   = |match;
   assign full  = used_ff == CW'(SLOTS);
   assign alloc = !hit && !full;
   assign evict = !hit && full;

   always_comb begin
      priority if (hit) begin
         sel_idx = hit_idx;
      end else if (alloc) begin
         sel_idx = used_ff[RW-1:0];
      end else begin
         sel_idx = lru_idx;
      end
   end

   assign needs_fill = hit ? slot_dirty_ff[sel_idx] : 1'b1;
   assign ev_key     = evict ? slot_key_ff[sel_idx] : '0;
   assign lim        = slot_rank_ff[sel_idx];

   // recency update: touched slot to rank 0, younger used slots age by one (all used slots on an allocation)
   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         if (RW'(i) == sel_idx) begin
            slot_rank_in[i] = '0;
         end else if (used_vec[i] && (alloc || slot_rank_ff[i] < lim)) begin
            slot_rank_in[i] = slot_rank_ff[i] + RW'(1);
         end else begin
            slot_rank_in[i] = slot_rank_ff[i];
         end
      end
   end

   always_comb begin
      slot_dirty_in          = slot_dirty_ff;
      slot_dirty_in[sel_idx] = needs_fill && !req_avail_ff;
   end

   always_ff @(posedge clock) begin
      if (req_valid_ff) begin
         for (int i = 0; i < SLOTS; i++) begin
            slot_rank_ff[i] <= slot_rank_in[i];
         end
         if (!hit) begin
            slot_key_ff[sel_idx] <= req_key_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_dirty_ff <= '1;
         used_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= req_valid_ff;
         if (req_valid_ff) begin
            slot_dirty_ff <= slot_dirty_in;
            if (alloc) begin
               used_ff <= used_ff + CW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid_ff) begin
         rsp_slot_ff          <= SLOT_W'(sel_idx);
         rsp_hit_ff           <= hit;
         rsp_evicted_ff       <= evict;
         rsp_evicted_index_ff <= ev_key;
         rsp_needs_fill_ff    <= needs_fill;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_slot          = rsp_slot_ff;
   assign rsp_hit           = rsp_hit_ff;
   assign rsp_evicted       = rsp_evicted_ff;
   assign rsp_evicted_index = rsp_evicted_index_ff;
   assign rsp_needs_fill    = rsp_needs_fill_ff;

   a_one_result: assert property (@(posedge clock) disable iff (reset)
      req_valid_ff |=> rsp_valid)
      else $error("item in input register produced no result");

   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_hit && rsp_evicted))
      else $error("hit and eviction reported together");

   a_miss_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> rsp_needs_fill)
      else $error("miss did not report a fill");

   a_evict_only_full: assert property (@(posedge clock) disable iff (reset)
      req_valid_ff && used_ff != CW'(SLOTS) |=> !rsp_evicted)
      else $error("eviction while free slots remained");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= CW'(SLOTS))
      else $error("fill count beyond slot count");

endmodule

FILE: tb/lru_slot_cache_core_tb.sv
// ----------------------------------------------------------------------------
// lru_slot_cache_core_tb
// Self-checking bench for the LRU slot cache core. Lookups are sent with
// random gaps; a cycle-level predictor of keys, ranks, dirty marks and the
// used-slot count computes each result, which is compared field by field
// with the strobed output.
// ----------------------------------------------------------------------------
module lru_slot_cache_core_tb;
   import lsc_pkg::*;

   localparam int SLOTS        = 16;
   localparam int RANDOM_ITEMS = 1830;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int POOL_MAX     = 24;

   typedef struct {
      slot_type slot;
      logic     hit;
      logic     evicted;
      key_type  evicted_index;
      logic     needs_fill;
   } lookup_result_type;

   logic     clock;
   logic     reset;
   logic     start;
   logic     busy;
   key_type  req_range_index;
   logic     req_data_available;
   logic     rsp_valid;
   slot_type rsp_slot;
   logic     rsp_hit;
   logic     rsp_evicted;
   key_type  rsp_evicted_index;
   logic     rsp_needs_fill;

   // predictor state
   key_type cached_key [SLOTS];
   int      cached_rank [SLOTS];
   bit      cached_dirty [SLOTS];
   int      slots_used;
   key_type last_evicted_key;

   lookup_result_type expected_lookups[$];

   int error_count;
   int items_sent;
   int hit_count;
   int eviction_count;
   int fill_clear_count;
   int cycle_count;
   int max_gap;

   lru_slot_cache_core #(
      .SLOTS(SLOTS)
   ) u_dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_range_index    (req_range_index),
      .req_data_available (req_data_available),
      .rsp_valid          (rsp_valid),
      .rsp_slot           (rsp_slot),
      .rsp_hit            (rsp_hit),
      .rsp_evicted        (rsp_evicted),
      .rsp_evicted_index  (rsp_evicted_index),
      .rsp_needs_fill     (rsp_needs_fill)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic lookup_result_type predict_lookup(key_type k, logic avail);
      lookup_result_type r;
      int  s;
      int  lim;
      bit  found;
      bit  lru_found;
      r = '{default: '0};
      s = 0;
      found = 1'b0;
      lru_found = 1'b0;
      for (int i = 0; i < slots_used; i++) begin
         if (!found && cached_key[i] == k) begin
            found = 1'b1;
            s = i;
         end
      end
      if (found) begin
         lim = cached_rank[s];
         hit_count++;
      end else if (slots_used < SLOTS) begin
         s = slots_used;
         slots_used++;
         cached_key[s] = k;
         cached_dirty[s] = 1'b1;
         lim = SLOTS;
      end else begin
         // full: reuse the slot holding the oldest rank
         for (int i = 0; i < SLOTS; i++) begin
            if (!lru_found && cached_rank[i] == SLOTS - 1) begin
               lru_found = 1'b1;
               s = i;
            end
         end
         r.evicted = 1'b1;
         r.evicted_index = cached_key[s];
         last_evicted_key = cached_key[s];
         cached_key[s] = k;
         cached_dirty[s] = 1'b1;
         lim = cached_rank[s];
         eviction_count++;
      end
      for (int i = 0; i < slots_used; i++) begin
         if (i != s && cached_rank[i] < lim) cached_rank[i]++;
      end
      cached_rank[s] = 0;
      r.slot = slot_type'(s);
      r.hit = found;
      r.needs_fill = cached_dirty[s];
      if (cached_dirty[s] && avail) begin
         cached_dirty[s] = 1'b0;
         fill_clear_count++;
      end
      return r;
   endfunction

   // result check first, then prediction of the item accepted at this edge
   always @(posedge clock) begin
      lookup_result_type want;
      if (!reset) begin
         if (rsp_valid) begin
            if (expected_lookups.size() == 0) begin
               error_count++;
               $display("%0t: result with nothing expected, slot %0d hit %0b", $time,
                        rsp_slot, rsp_hit);
            end else begin
               want = expected_lookups.pop_front();
               if (rsp_slot !== want.slot) begin
                  error_count++;
                  $display("%0t: slot mismatch, expected %0d actual %0d", $time,
                           want.slot, rsp_slot);
               end
               if (rsp_hit !== want.hit) begin
                  error_count++;
                  $display("%0t: hit mismatch, expected %0b actual %0b", $time,
                           want.hit, rsp_hit);
               end
               if (rsp_evicted !== want.evicted) begin
                  error_count++;
                  $display("%0t: evicted mismatch, expected %0b actual %0b", $time,
                           want.evicted, rsp_evicted);
               end
               if (rsp_evicted_index !== want.evicted_index) begin
                  error_count++;
                  $display("%0t: evicted_index mismatch, expected %h actual %h", $time,
                           want.evicted_index, rsp_evicted_index);
               end
               if (rsp_needs_fill !== want.needs_fill) begin
                  error_count++;
                  $display("%0t: needs_fill mismatch, expected %0b actual %0b", $time,
                           want.needs_fill, rsp_needs_fill);
               end
            end
         end
         if (start && !busy) begin
            want = predict_lookup(req_range_index, req_data_available);
            expected_lookups = {expected_lookups, want};
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results outstanding", $time,
                  expected_lookups.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic send_lookup(input key_type k, input logic avail);
      int gap;
      gap = $urandom_range(0, max_gap);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_range_index <= k;
      req_data_available <= avail;
      @(posedge clock);
      while (busy) @(posedge clock);
      items_sent++;
   endtask

   task automatic wait_for_results();
      start <= 1'b0;
      @(posedge clock);
      while (expected_lookups.size() != 0) @(posedge clock);
   endtask

   // extreme keys, dirty misses, then hits that clear and find clean marks
   task automatic test_first_allocations();
      send_lookup(20'h00000, 1'b0);
      send_lookup(20'hFFFFF, 1'b0);
      send_lookup(20'hAAAAA, 1'b1);
      send_lookup(20'h55555, 1'b0);
      send_lookup(20'h00000, 1'b1);
      send_lookup(20'h00000, 1'b0);
      // oldest entry hit
      send_lookup(20'hFFFFF, 1'b1);
   endtask

   task automatic test_fill_to_capacity();
      for (int i = 0; i < SLOTS - 4; i++)
         send_lookup(key_type'(i * 20'h11111 + 20'h10), logic'(i % 2));
   endtask

   task automatic test_lru_eviction();
      send_lookup(20'h12345, 1'b1);
      send_lookup(20'h12345, 1'b0);
      send_lookup(20'hFEDCB, 1'b0);
      // bring back the key just thrown out
      wait_for_results();
      send_lookup(last_evicted_key, 1'b1);
      send_lookup(20'h00001, 1'b1);
      send_lookup(20'h80000, 1'b0);
   endtask

   task automatic test_random_lookups();
      key_type key_pool [POOL_MAX];
      int      pool_size;
      int      pick;
      key_type k;
      pool_size = 1;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 200 == 0) begin
            // small pools mostly hit, larger ones thrash the lru order
            pick = $urandom_range(0, 2);
            pool_size = (pick == 0) ? 6 : (pick == 1) ? 17 : POOL_MAX;
            for (int j = 0; j < POOL_MAX; j++) key_pool[j] = key_type'($urandom);
         end
         if (n % 150 == 0) max_gap = 0;
         else if (n % 150 == 40) max_gap = 3;
         if (n == RANDOM_ITEMS / 2) wait_for_results();
         pick = $urandom_range(0, 99);
         if (pick < 75) k = key_pool[$urandom_range(0, pool_size - 1)];
         else if (pick < 85) k = last_evicted_key;
         else k = key_type'($urandom);
         send_lookup(k, logic'($urandom_range(0, 1)));
      end
   endtask

   initial begin
      error_count = 0;
      items_sent = 0;
      hit_count = 0;
      eviction_count = 0;
      fill_clear_count = 0;
      cycle_count = 0;
      max_gap = 3;
      slots_used = 0;
      last_evicted_key = '0;
      for (int i = 0; i < SLOTS; i++) begin
         cached_key[i] = '0;
         cached_rank[i] = 0;
         cached_dirty[i] = 1'b1;
      end
      reset <= 1'b1;
      start <= 1'b0;
      req_range_index <= '0;
      req_data_available <= 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_first_allocations();
      test_fill_to_capacity();
      test_lru_eviction();
      wait_for_results();
      test_random_lookups();

      wait_for_results();
      repeat (4) @(posedge clock);
      $display("covered %0d lookups: %0d hits, %0d evictions, %0d dirty marks cleared",
               items_sent, hit_count, eviction_count, fill_clear_count);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

FILE: files.f
src/lsc_pkg.sv
src/lru_slot_cache_core.sv
tb/lru_slot_cache_core_tb.sv
